### rtl/gblp_pkg.sv
// gblp_pkg: shared widths, reset values, register codes and word types
// for the boundary-layer point generator; used by every rtl file, depends on nothing
package gblp_pkg;

    // default parameter values
    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    // field widths
    localparam int COORD_W = 32;
    localparam int MAG_W   = 33;
    localparam int LEN_W   = 34;
    localparam int HGT_W   = 48;
    localparam int PIDX_W  = 6;
    localparam int CNT_W   = 7;
    localparam int FH_W    = 31;
    localparam int GR_W    = 19;
    localparam int CIDX_W  = 2;

    // multiply-divide unit widths
    localparam int MA_W      = 48;
    localparam int MB_W      = 40;
    localparam int MP_W      = MA_W + MB_W;
    localparam int MDIG_W    = 8;
    localparam int MUL_STEPS = MB_W / MDIG_W;
    localparam int QUO_W     = 35;
    localparam int RAD_W     = 2 * LEN_W;
    localparam int SREM_W    = LEN_W + 2;

    localparam logic [HGT_W-1:0] HGT_CAP = {HGT_W{1'b1}};

    // register reset values
    localparam logic [CNT_W-1:0] RST_POINT_COUNT  = 7'd64;
    localparam logic [FH_W-1:0]  RST_FIRST_HEIGHT = 31'd65536;
    localparam logic [GR_W-1:0]  RST_GROWTH       = 19'd78643;

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_POINT_COUNT  = 2'd0,
        CFG_FIRST_HEIGHT = 2'd1,
        CFG_GROWTH       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] point_count;
        logic [FH_W-1:0]  first_height;
        logic [GR_W-1:0]  growth;
    } t_cfg;

    // classified segment, lane 0 is x
    typedef struct packed {
        logic [2:0][COORD_W-1:0] start;
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
        logic                    degen;
    } t_seg;

    typedef struct packed {
        logic [PIDX_W-1:0]       index;
        logic [2:0][COORD_W-1:0] pt;
        logic                    degen;
        logic                    last;
    } t_res;

    // start plus or minus the clamped offset, saturated to 32 bits
    function automatic logic [COORD_W-1:0] place_coord(
        input logic [COORD_W-1:0] st,
        input logic               neg,
        input logic [MAG_W-1:0]   mag,
        input logic [QUO_W-1:0]   q
    );
        logic [MAG_W-1:0]   qc;
        logic signed [QUO_W-1:0] v;
        logic signed [QUO_W-1:0] sx;
        logic signed [QUO_W-1:0] qx;
        qc = (q > {2'b00, mag}) ? mag : q[MAG_W-1:0];
        sx = $signed({{3{st[COORD_W-1]}}, st});
        qx = $signed({2'b00, qc});
        v  = neg ? (sx - qx) : (sx + qx);
        if (v > 35'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -35'sd2147483648)
            return 32'h8000_0000;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

### rtl/gblp_front.sv
// gblp_front: takes segment words, forms deltas and magnitudes, holds them
// in a two-entry queue for the back end; depends on gblp_pkg
module gblp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [2:0][gblp_pkg::COORD_W-1:0] i_start,
    input  logic [2:0][gblp_pkg::COORD_W-1:0] i_end,
    output logic                             o_seg_valid,
    output gblp_pkg::t_seg                   o_seg,
    input  logic                             i_seg_take
);
    import gblp_pkg::*;

    t_seg       cls;
    t_seg       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;

    // classify: signed delta per axis, its magnitude and sign
    always_comb begin
        logic signed [MAG_W-1:0] d;
        cls.degen = 1'b1;
        for (int a = 0; a < 3; a++) begin
            d = $signed({i_end[a][COORD_W-1], i_end[a]})
                - $signed({i_start[a][COORD_W-1], i_start[a]});
            cls.start[a] = i_start[a];
            cls.neg[a]   = d[MAG_W-1];
            cls.mag[a]   = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
            if (d != '0)
                cls.degen = 1'b0;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign do_push     = i_push && !o_full;
    assign o_seg_valid = (r_cnt != 2'd0);
    assign o_seg       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (do_push)
            r_q[r_wp] <= cls;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push)
                r_wp <= !r_wp;
            if (i_seg_take && o_seg_valid)
                r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(i_seg_take && o_seg_valid);
        end
    end

endmodule

### rtl/gblp_muldiv.sv
// gblp_muldiv: floor(a*b/c) or the bare product a*b, eight multiplier bits
// per cycle then one quotient bit per cycle; depends on gblp_pkg
module gblp_muldiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_mul_only,
    input  logic [gblp_pkg::MA_W-1:0]   i_a,
    input  logic [gblp_pkg::MB_W-1:0]   i_b,
    input  logic [gblp_pkg::MA_W-1:0]   i_c,
    output logic                        o_done,
    output logic [gblp_pkg::MP_W-1:0]   o_prod,
    output logic [gblp_pkg::QUO_W-1:0]  o_quo
);
    import gblp_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_LOAD, M_DIV} t_mstate;

    t_mstate            r_state;
    logic [5:0]         r_cnt;
    logic               r_mo;
    logic               r_done;
    logic [MA_W-1:0]    r_a;
    logic [MB_W-1:0]    r_b;
    logic [MA_W-1:0]    r_c;
    logic [MP_W-1:0]    r_acc;
    logic [MA_W-1:0]    r_rem;
    logic [QUO_W-1:0]   r_lo;
    logic [QUO_W-1:0]   r_quo;

    logic [MA_W+MDIG_W-1:0] pp;
    logic [MA_W:0]          rem2;
    logic                   ge;

    // one partial product and one restoring divide step
    assign pp   = r_a * r_b[MB_W-1 -: MDIG_W];
    assign rem2 = {r_rem, r_lo[QUO_W-1]};
    assign ge   = (rem2 >= {1'b0, r_c});

    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_quo  = r_quo;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_c     <= i_c;
                        r_mo    <= i_mul_only;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_acc <= (r_acc << MDIG_W) + MP_W'(pp);
                    r_b   <= r_b << MDIG_W;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(MUL_STEPS - 1)) begin
                        if (r_mo) begin
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end else begin
                            r_state <= M_LOAD;
                        end
                    end
                end
                M_LOAD: begin
                    r_rem   <= r_acc[QUO_W+MA_W-1:QUO_W];
                    r_lo    <= r_acc[QUO_W-1:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    r_rem <= ge ? MA_W'(rem2 - {1'b0, r_c}) : rem2[MA_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], ge};
                    r_lo  <= r_lo << 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(QUO_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

### rtl/gblp_back.sv
// gblp_back: per-segment sequencer: length root, height pass into the
// arc memory, point placement over three multiply-divide lanes, result queue
// depends on gblp_pkg and gblp_muldiv
module gblp_back #(
    parameter int MAX_POINTS = gblp_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = gblp_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gblp_pkg::t_cfg i_cfg,
    input  logic           i_seg_valid,
    input  gblp_pkg::t_seg i_seg,
    output logic           o_seg_take,
    output logic           o_empty,
    output gblp_pkg::t_res o_res,
    input  logic           i_pop
);
    import gblp_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQW, S_SQRT, S_SETUP, S_HSUM, S_HMUL,
        S_EADDR, S_EPOS, S_EPW, S_ECRD, S_ECW, S_EOUT
    } t_state;

    t_state              r_state;
    t_seg                r_seg;
    logic [LEN_W-1:0]    r_len;
    logic [IDX_W-1:0]    r_k;
    logic [IDX_W-1:0]    r_last;
    logic [IDX_W-1:0]    r_i;
    logic [HGT_W-1:0]    r_h;
    logic [HGT_W-1:0]    r_part;
    logic [HGT_W-1:0]    r_base;
    logic [HGT_W-1:0]    r_total;
    logic                r_found;
    logic                r_scaled;
    logic                r_uniform;
    logic                r_degen;
    logic                r_addbase;
    logic [LEN_W-1:0]    r_pos;
    logic [RAD_W-1:0]    r_rad;
    logic [SREM_W-1:0]   r_srem;
    logic [LEN_W-1:0]    r_root;
    logic [5:0]          r_scnt;
    t_res                r_res;

    // arc memory, one write and one registered read at r_k
    logic [HGT_W-1:0]    mem [MAX_POINTS];
    logic [HGT_W-1:0]    r_rd;
    logic                mem_we;
    logic [HGT_W-1:0]    mem_wd;

    // result queue
    t_res                r_oq [2];
    logic                r_owp;
    logic                r_orp;
    logic [1:0]          r_ocnt;
    logic                out_full;
    logic                res_push;

    // lanes
    logic [2:0]          lane_start;
    logic                lane_mo;
    logic [2:0][MA_W-1:0] lane_a;
    logic [2:0][MB_W-1:0] lane_b;
    logic [MA_W-1:0]     lane_c;
    logic [2:0]          lane_done;
    logic [2:0][MP_W-1:0] lane_prod;
    logic [2:0][QUO_W-1:0] lane_quo;

    logic [IDX_W-1:0]    cfg_last;
    logic [RAD_W-1:0]    sumsq;
    logic [SREM_W+1:0]   sq_cur;
    logic [SREM_W+1:0]   sq_trial;
    logic                sq_ge;
    logic [HGT_W:0]      hsum;
    logic [HGT_W-1:0]    hsum_sat;
    logic [MP_W-1:0]     grow_sh;
    logic [HGT_W-1:0]    grow_h;
    logic                is_unity;
    logic [IDX_W:0]      spill_num;
    logic [IDX_W:0]      spill_den;

    // effective point count, kept as the last index
    always_comb begin
        if (i_cfg.point_count < CNT_W'(2))
            cfg_last = IDX_W'(1);
        else if (i_cfg.point_count > CNT_W'(MAX_POINTS))
            cfg_last = IDX_W'(MAX_POINTS - 1);
        else
            cfg_last = IDX_W'(i_cfg.point_count - CNT_W'(1));
    end

    // squares, root step, height sum and growth
    assign sumsq    = RAD_W'(lane_prod[0][2*MAG_W-1:0]) + RAD_W'(lane_prod[1][2*MAG_W-1:0])
                    + RAD_W'(lane_prod[2][2*MAG_W-1:0]);
    assign sq_cur   = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_cur >= sq_trial);
    assign hsum     = {1'b0, r_part} + {1'b0, r_h};
    assign hsum_sat = hsum[HGT_W] ? HGT_CAP : hsum[HGT_W-1:0];
    assign grow_sh  = lane_prod[0] >> FRAC_BITS;
    assign grow_h   = (|grow_sh[MP_W-1:HGT_W]) ? HGT_CAP : grow_sh[HGT_W-1:0];
    assign is_unity = ({13'd0, i_cfg.growth} == (32'd1 << FRAC_BITS));
    assign spill_num = {1'b0, r_k} - {1'b0, r_i} + (IDX_W+1)'(1);
    assign spill_den = {1'b0, r_last} - {1'b0, r_i} + (IDX_W+1)'(1);

    assign o_seg_take = (r_state == S_IDLE) && i_seg_valid;
    assign out_full   = (r_ocnt == 2'd2);
    assign res_push   = (r_state == S_EOUT) && !out_full;

    // lane operands
    always_comb begin
        lane_start = '0;
        lane_mo    = 1'b0;
        lane_c     = MA_W'(r_len);
        for (int a = 0; a < 3; a++) begin
            lane_a[a] = (r_state == S_SQ) ? MA_W'(r_seg.mag[a]) : MA_W'(r_pos);
            lane_b[a] = MB_W'(r_seg.mag[a]);
        end
        case (r_state)
            S_SQ: begin
                lane_start = 3'b111;
                lane_mo    = 1'b1;
            end
            S_HSUM: begin
                lane_start[0] = (r_k != r_last);
                lane_mo       = 1'b1;
                lane_a[0]     = r_h;
                lane_b[0]     = MB_W'(i_cfg.growth);
            end
            S_EPOS: begin
                if (r_degen) begin
                    lane_start = '0;
                end else if (r_uniform) begin
                    lane_start[0] = 1'b1;
                    lane_a[0]     = MA_W'(r_k);
                    lane_b[0]     = MB_W'(r_len);
                    lane_c        = MA_W'(r_last);
                end else if (r_scaled) begin
                    lane_start[0] = 1'b1;
                    lane_a[0]     = r_rd;
                    lane_b[0]     = MB_W'(r_len);
                    lane_c        = r_total;
                end else if (r_k >= r_i) begin
                    lane_start[0] = 1'b1;
                    lane_a[0]     = MA_W'(spill_num);
                    lane_b[0]     = MB_W'(MA_W'(r_len) - r_base);
                    lane_c        = MA_W'(spill_den);
                end
            end
            S_ECRD: lane_start = 3'b111;
            default: lane_start = '0;
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        gblp_muldiv u_md (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (lane_start[g]),
            .i_mul_only (lane_mo),
            .i_a        (lane_a[g]),
            .i_b        (lane_b[g]),
            .i_c        (lane_c),
            .o_done     (lane_done[g]),
            .o_prod     (lane_prod[g]),
            .o_quo      (lane_quo[g])
        );
    end

    // arc memory
    assign mem_we = (r_state == S_SETUP) || (r_state == S_HSUM);
    assign mem_wd = (r_state == S_SETUP) ? '0 : hsum_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[r_k] <= mem_wd;
        r_rd <= mem[r_k];
    end

    // segment sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_last  <= IDX_W'(1);
            r_len   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_seg_valid) begin
                        r_seg   <= i_seg;
                        r_last  <= cfg_last;
                        r_k     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: begin
                    if (lane_done[0]) begin
                        r_rad   <= sumsq;
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_scnt  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= sq_ge ? SREM_W'(sq_cur - sq_trial) : SREM_W'(sq_cur);
                    r_root <= {r_root[LEN_W-2:0], sq_ge};
                    r_rad  <= r_rad << 2;
                    r_scnt <= r_scnt + 6'd1;
                    if (r_scnt == 6'(LEN_W - 1)) begin
                        r_len   <= {r_root[LEN_W-2:0], sq_ge};
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_degen   <= (r_len == '0);
                    r_uniform <= is_unity;
                    r_part    <= '0;
                    r_h       <= (i_cfg.first_height == '0) ? HGT_W'(1)
                                                           : HGT_W'(i_cfg.first_height);
                    r_found   <= 1'b0;
                    if (r_len == '0 || is_unity) begin
                        r_k     <= '0;
                        r_state <= S_EADDR;
                    end else begin
                        r_k     <= IDX_W'(1);
                        r_state <= S_HSUM;
                    end
                end
                S_HSUM: begin
                    r_part <= hsum_sat;
                    if (!r_found && (hsum_sat >= HGT_W'(r_len) || r_k == r_last)) begin
                        r_found <= 1'b1;
                        r_i     <= r_k;
                        r_base  <= r_part;
                    end
                    if (r_k == r_last) begin
                        r_total  <= hsum_sat;
                        r_scaled <= (hsum_sat <= HGT_W'(r_len));
                        r_k      <= '0;
                        r_state  <= S_EADDR;
                    end else begin
                        r_state <= S_HMUL;
                    end
                end
                S_HMUL: begin
                    if (lane_done[0]) begin
                        r_h     <= grow_h;
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_HSUM;
                    end
                end
                S_EADDR: r_state <= S_EPOS;
                S_EPOS: begin
                    r_res.index <= PIDX_W'(r_k);
                    r_res.degen <= r_degen;
                    r_res.last  <= (r_k == r_last);
                    if (r_degen) begin
                        r_res.pt <= r_seg.start;
                        r_state  <= S_EOUT;
                    end else if (r_uniform || r_scaled) begin
                        r_addbase <= 1'b0;
                        r_state   <= S_EPW;
                    end else if (r_k < r_i) begin
                        r_pos   <= LEN_W'(r_rd);
                        r_state <= S_ECRD;
                    end else begin
                        r_addbase <= 1'b1;
                        r_state   <= S_EPW;
                    end
                end
                S_EPW: begin
                    if (lane_done[0]) begin
                        r_pos <= LEN_W'((r_addbase ? r_base : '0) + HGT_W'(lane_quo[0]));
                        r_state <= S_ECRD;
                    end
                end
                S_ECRD: r_state <= S_ECW;
                S_ECW: begin
                    if (lane_done[0]) begin
                        for (int a = 0; a < 3; a++)
                            r_res.pt[a] <= place_coord(r_seg.start[a], r_seg.neg[a],
                                                       r_seg.mag[a], lane_quo[a]);
                        r_state <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    if (!out_full) begin
                        if (r_k == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_state <= S_EADDR;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result queue
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (res_push)
            r_oq[r_owp] <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (res_push)
                r_owp <= !r_owp;
            if (i_pop && !o_empty)
                r_orp <= !r_orp;
            r_ocnt <= r_ocnt + 2'(res_push) - 2'(i_pop && !o_empty);
        end
    end

    // point index stays inside the segment
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k <= r_last))
        else $error("point index past last point");

    // zero root only for a segment with no delta
    a_len_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> ((r_len == '0) == r_seg.degen))
        else $error("length root disagrees with degenerate flag");

    // stored partial sums below the spill index lie inside the segment
    a_spill_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EPOS && !r_degen && !r_uniform && !r_scaled && r_k < r_i)
        |-> (r_rd < HGT_W'(r_len)))
        else $error("spill position beyond segment length");

    // result queue never overfills
    a_oq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result queue overflow");

endmodule

### rtl/geometric_boundary_layer_points_unit.sv
// geometric_boundary_layer_points_unit: top level with the register file,
// front classifier and back sequencer; depends on gblp_pkg, gblp_front, gblp_back
//
// Each segment word (start and end, signed Q16.16) yields point_count point words
// (clamped to 2 up to MAX_POINTS) with geometric spacing; the last carries the last flag.
// A segment first takes the squared length and its 34-step root, then on a
// geometric growth the height pass into the arc memory, one cell at a time,
// then for each point up to two passes through the bit-serial multiply-divide
// lanes (5 multiply steps, a load step and 35 quotient bits each). The input queue
// holds two segments and the result queue two points; the user must write registers
// only while the block is idle, the block itself does not enforce it.
module geometric_boundary_layer_points_unit #(
    parameter int MAX_POINTS = gblp_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = gblp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [gblp_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [gblp_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [gblp_pkg::COORD_W-1:0] i_start_z,
    input  logic signed [gblp_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [gblp_pkg::COORD_W-1:0] i_end_y,
    input  logic signed [gblp_pkg::COORD_W-1:0] i_end_z,
    output logic                              empty,
    input  logic                              pop,
    output logic [gblp_pkg::PIDX_W-1:0]       o_point_index,
    output logic signed [gblp_pkg::COORD_W-1:0] o_point_x,
    output logic signed [gblp_pkg::COORD_W-1:0] o_point_y,
    output logic signed [gblp_pkg::COORD_W-1:0] o_point_z,
    output logic                              o_degenerate,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gblp_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [gblp_pkg::FH_W-1:0]         i_cfg_data
);
    import gblp_pkg::*;

    t_cfg r_cfg;
    t_seg seg;
    logic seg_valid;
    logic seg_take;
    t_res res;

    // register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_count  <= RST_POINT_COUNT;
            r_cfg.first_height <= RST_FIRST_HEIGHT;
            r_cfg.growth       <= RST_GROWTH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POINT_COUNT:  r_cfg.point_count  <= i_cfg_data[CNT_W-1:0];
                CFG_FIRST_HEIGHT: r_cfg.first_height <= i_cfg_data;
                CFG_GROWTH:       r_cfg.growth       <= i_cfg_data[GR_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    gblp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_start     ({i_start_z, i_start_y, i_start_x}),
        .i_end       ({i_end_z, i_end_y, i_end_x}),
        .o_seg_valid (seg_valid),
        .o_seg       (seg),
        .i_seg_take  (seg_take)
    );

    gblp_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_seg_valid (seg_valid),
        .i_seg       (seg),
        .o_seg_take  (seg_take),
        .o_empty     (empty),
        .o_res       (res),
        .i_pop       (pop)
    );

    // result word fields
    assign o_point_index = res.index;
    assign o_point_x     = res.pt[0];
    assign o_point_y     = res.pt[1];
    assign o_point_z     = res.pt[2];
    assign o_degenerate  = res.degen;
    assign o_last        = res.last;

endmodule

### tb/testbench.sv
// testbench: self-checking bench for geometric_boundary_layer_points_unit
// holds its own fixed-point grid predictor, queue-style drivers and a result checker
// depends on rtl/gblp_pkg.sv and the rtl of the block
module testbench;
    import gblp_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 40000;
    localparam int TAIL_CYCLES = 200;
    localparam logic [63:0] CAP48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [GR_W-1:0] GROWTH_ONE = 19'd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
    } t_segment;

    typedef struct packed {
        logic [PIDX_W-1:0]  idx;
        logic [COORD_W-1:0] x, y, z;
        logic               degen;
        logic               last;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, o_cfg_ready;
    logic signed [COORD_W-1:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [COORD_W-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic [PIDX_W-1:0] o_point_index;
    logic signed [COORD_W-1:0] o_point_x, o_point_y, o_point_z;
    logic o_degenerate, o_last;
    logic i_cfg_valid = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [FH_W-1:0] i_cfg_data = '0;

    // predictor copy of the registers
    logic [CNT_W-1:0] grid_count = RST_POINT_COUNT;
    logic [FH_W-1:0]  grid_height = RST_FIRST_HEIGHT;
    logic [GR_W-1:0]  grid_growth = RST_GROWTH;

    t_point pending_points[$];
    int errors = 0;
    int idle_cycles = 0;
    int cycle_count = 0;
    int burst_left = 0;

    geometric_boundary_layer_points_unit u_top (.*);

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // quotient of a wide product, all ones when it does not fit 64 bits or the divisor is zero
    function automatic logic [63:0] wide_quot(input logic [127:0] num, input logic [63:0] den);
        logic [127:0] q;
        if (den == 0)
            return '1;
        q = num / {64'b0, den};
        if (q[127:64] != 0)
            return '1;
        return q[63:0];
    endfunction

    function automatic logic [63:0] next_height(input logic [63:0] h);
        logic [127:0] pr;
        pr = ({64'b0, h} * {109'b0, grid_growth}) >> FRAC_BITS_DEF;
        return (pr > {64'b0, CAP48}) ? CAP48 : pr[63:0];
    endfunction

    // work out every point of one segment and queue them
    task automatic predict_segment_points(input t_segment sg);
        longint st[3], dl[3], v;
        logic [63:0] mg[3], part[64], pos[64];
        logic [63:0] len, h, s, total, base, q;
        logic [127:0] sq, c128;
        int n, k, a, i;
        t_point p;
        n = (grid_count < 2) ? 2 : (grid_count > 64) ? 64 : int'(grid_count);
        st[0] = longint'(sg.sx); st[1] = longint'(sg.sy); st[2] = longint'(sg.sz);
        dl[0] = longint'(sg.ex) - st[0];
        dl[1] = longint'(sg.ey) - st[1];
        dl[2] = longint'(sg.ez) - st[2];
        sq = '0;
        for (a = 0; a < 3; a++) begin
            mg[a] = (dl[a] < 0) ? -dl[a] : dl[a];
            sq = sq + {64'b0, mg[a]} * {64'b0, mg[a]};
        end
        // exact integer root
        len = '0;
        for (int b = 33; b >= 0; b--) begin
            c128 = {64'b0, len | (64'd1 << b)};
            if (c128 * c128 <= sq)
                len = c128[63:0];
        end
        if (len == 0) begin
            for (k = 0; k < n; k++) pos[k] = '0;
        end else if (grid_growth == GROWTH_ONE) begin
            for (k = 0; k < n; k++) pos[k] = (64'(k) * len) / 64'(n - 1);
        end else begin
            h = (grid_height == 0) ? 64'd1 : {33'b0, grid_height};
            part[0] = '0;
            for (k = 1; k < n; k++) begin
                s = part[k-1] + h;
                part[k] = (s > CAP48) ? CAP48 : s;
                if (k < n - 1)
                    h = next_height(h);
            end
            total = part[n-1];
            if (total <= len) begin
                // geometric total fits, stretch to the length
                for (k = 0; k < n; k++)
                    pos[k] = wide_quot({64'b0, part[k]} * {64'b0, len}, total);
            end else begin
                // heights spill past the length, spread the rest evenly
                i = 1;
                while (i < n - 1 && part[i] < len) i++;
                base = part[i-1];
                for (k = 0; k < i; k++) pos[k] = part[k];
                for (k = i; k < n; k++)
                    pos[k] = base + (64'(k - i + 1) * (len - base)) / 64'(n - i);
            end
        end
        for (k = 0; k < n; k++) begin
            p.idx = k[PIDX_W-1:0];
            for (a = 0; a < 3; a++) begin
                v = st[a];
                if (len != 0) begin
                    q = wide_quot({64'b0, pos[k]} * {64'b0, mg[a]}, len);
                    if (q > mg[a]) q = mg[a];
                    v = (dl[a] < 0) ? v - longint'(q) : v + longint'(q);
                end
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                if (a == 0) p.x = v[31:0];
                else if (a == 1) p.y = v[31:0];
                else p.z = v[31:0];
            end
            p.degen = (len == 0);
            p.last = (k == n - 1);
            pending_points.insert(pending_points.size(), p);
        end
    endtask

    // send one segment word, bursts with random gaps, push left high afterwards
    task automatic send_segment(input t_segment sg);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 5);
        end
        burst_left--;
        push <= 1'b1;
        i_start_x <= sg.sx; i_start_y <= sg.sy; i_start_z <= sg.sz;
        i_end_x <= sg.ex; i_end_y <= sg.ey; i_end_z <= sg.ez;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_segment_points(sg);
    endtask

    // let the block drain before touching registers
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [FH_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_POINT_COUNT:  grid_count = data[CNT_W-1:0];
            CFG_FIRST_HEIGHT: grid_height = data;
            CFG_GROWTH:       grid_growth = data[GR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input int cnt, input logic [FH_W-1:0] fh, input logic [GR_W-1:0] gr);
        wait_drained();
        write_reg(CFG_POINT_COUNT, FH_W'(cnt));
        write_reg(CFG_FIRST_HEIGHT, fh);
        write_reg(CFG_GROWTH, {12'b0, gr});
    endtask

    function automatic t_segment make_seg(input int sx, sy, sz, ex, ey, ez);
        t_segment sg;
        sg.sx = sx; sg.sy = sy; sg.sz = sz;
        sg.ex = ex; sg.ey = ey; sg.ez = ez;
        return sg;
    endfunction

    // segment with random offsets of up to span from a random start
    function automatic t_segment near_seg(input int span);
        t_segment sg;
        sg.sx = $signed($urandom) >>> 2;
        sg.sy = $signed($urandom) >>> 2;
        sg.sz = $signed($urandom) >>> 2;
        sg.ex = sg.sx + $signed($urandom_range(0, 2 * span)) - span;
        sg.ey = sg.sy + $signed($urandom_range(0, 2 * span)) - span;
        sg.ez = sg.sz + $signed($urandom_range(0, 2 * span)) - span;
        return sg;
    endfunction

    // default registers: degenerate, full span and a short x segment at 64 points
    task automatic test_reset_defaults();
        send_segment(make_seg(5, -7, 9, 5, -7, 9));
        send_segment(make_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_segment(make_seg(0, 0, 0, 32'h0040_0000, 0, 0));
    endtask

    // uniform growth at two and nine points, coordinate extremes
    task automatic test_uniform_extremes();
        set_grid(2, 1, GROWTH_ONE);
        send_segment(make_seg(32'h7fff_ffff, 32'h8000_0000, 0,
                              32'h8000_0000, 32'h7fff_ffff, 0));
        send_segment(make_seg(0, 0, 0, 0, 0, 0));
        send_segment(make_seg(1, 1, 1, 2, 1, 1));
        set_grid(9, 65536, GROWTH_ONE);
        send_segment(make_seg(0, 0, 0, -100000, 300000, 7));
        send_segment(make_seg(-3, 0, 0, 3, 0, 0));
    endtask

    // count below range, zero first height, largest growth, a write to the unused index
    task automatic test_low_count_zero_height();
        set_grid(0, 0, 19'd262144);
        send_segment(make_seg(10, 20, 30, 10, 20, 90));
        set_grid(3, 0, 19'd262144);
        send_segment(make_seg(0, 0, 0, 5, 0, 0));
        send_segment(make_seg(0, 0, 0, 32'h0100_0000, 32'h0100_0000, 0));
        wait_drained();
        write_reg(CFG_UNUSED, '1);
        send_segment(make_seg(-50, -50, -50, 50, 50, 50));
    endtask

    // count above range, largest first height, shrinking cells, then default growth
    task automatic test_high_count_shrink();
        set_grid(127, 31'h7fff_ffff, 19'd32768);
        send_segment(make_seg(0, 0, 0, 32'h7fff_ffff, 0, 0));
        set_grid(6, 65536, 19'd40000);
        send_segment(make_seg(0, 0, 0, 32'h0010_0000, 0, 0));
        send_segment(make_seg(0, 0, 0, 32'h0000_8000, 0, 0));
        set_grid(5, 65536, RST_GROWTH);
        send_segment(make_seg(0, 0, 0, 32'h0010_0000, 0, 0));
        send_segment(make_seg(0, 0, 0, 32'h0001_0000, 0, 0));
        send_segment(make_seg(7, 7, 7, 7, 7, 7));
    endtask

    // random phases with random registers and mixed segments
    task automatic test_random_grids();
        t_segment sg;
        int cnt;
        logic [GR_W-1:0] gr;
        logic [FH_W-1:0] fh;
        for (int ph = 0; ph < 10; ph++) begin
            cnt = (ph == 4) ? 64 : $urandom_range(2, 9);
            case ($urandom_range(0, 3))
                0: gr = GROWTH_ONE;
                1: gr = GR_W'($urandom_range(16384, 65535));
                default: gr = GR_W'($urandom_range(65537, 262144));
            endcase
            case ($urandom_range(0, 2))
                0: fh = FH_W'($urandom_range(1, 65536));
                1: fh = FH_W'($urandom_range(65536, 4194304));
                default: fh = FH_W'($urandom);
            endcase
            set_grid(cnt, fh, gr);
            for (int j = 0; j < ((ph == 4) ? 3 : 23); j++) begin
                case ($urandom_range(0, 9))
                    0, 1: sg = make_seg($urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom);
                    2: begin
                        sg = near_seg(1000);
                        sg.ex = sg.sx; sg.ey = sg.sy; sg.ez = sg.sz;
                    end
                    3: sg = near_seg(64);
                    default: sg = near_seg($urandom_range(1, 1 << 24));
                endcase
                send_segment(sg);
            end
        end
    endtask

    // receiver stall pattern, chosen by bits 11:10 of the cycle count
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[11:10])
            2'd0: pop <= 1'b1;
            2'd1: pop <= 1'($urandom_range(0, 1));
            2'd2: pop <= (cycle_count % 7) != 0;
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_point p;
        if (i_rst_n && pop && !empty) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point word index %0d", $time, o_point_index);
                errors++;
            end else begin
                p = pending_points.pop_front();
                check_field("point_index", p.idx, o_point_index);
                check_field("point_x", $signed(p.x), o_point_x);
                check_field("point_y", $signed(p.y), o_point_y);
                check_field("point_z", $signed(p.z), o_point_z);
                check_field("degenerate", p.degen, o_degenerate);
                check_field("last", p.last, o_last);
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_uniform_extremes();
        test_low_count_zero_height();
        test_high_count_shrink();
        test_random_grids();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
